// ===== design/assert_macros.svh =====
// Assertion macros for the checker file of the decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSUD_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bsud: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define BSUD_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bsud: next-cycle property failed");

`endif

// ===== design/bsud_pkg.sv =====
// Types and constants shared by the decoder modules.
`timescale 1ns / 1ps
`default_nettype none

package bsud_pkg;

  // Encoding codes as they appear on the result port.
  localparam logic [2:0] ENC_NONE    = 3'd0;
  localparam logic [2:0] ENC_UTF8    = 3'd1;
  localparam logic [2:0] ENC_UTF16BE = 3'd2;
  localparam logic [2:0] ENC_UTF16LE = 3'd3;
  localparam logic [2:0] ENC_UTF32BE = 3'd4;
  localparam logic [2:0] ENC_UTF32LE = 3'd5;

  typedef enum logic [1:0] {
    KIND_CP    = 2'd0,
    KIND_ENC   = 2'd1,
    KIND_TRUNC = 2'd2,
    KIND_END   = 2'd3
  } kind_e;

  typedef enum logic {
    OP_BYTE   = 1'b0,
    OP_DETECT = 1'b1
  } op_e;

  // One queued operation from the front end to the back end.
  typedef struct packed {
    op_e        op;
    logic       fin;
    logic [2:0] enc;
    logic [1:0] rep_n;
    logic [7:0] b0;
    logic [7:0] b1;
  } op_t;

  typedef struct packed {
    logic full;
    logic avail;
  } q_stat_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] cp;
    logic [2:0]  enc;
  } res_t;

endpackage

`default_nettype wire

// ===== design/bsud_front.sv =====
// Front end: takes input bytes, sniffs the byte order mark and queues operations.
`timescale 1ns / 1ps
`default_nettype none

module bsud_front import bsud_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire logic [7:0] byte_in_i,
  input  wire logic    end_of_text_i,
  input  wire q_stat_t stat_i,
  output logic         push_o,
  output op_t          push_op_o
);

  localparam logic [1:0] PH_DETECT  = 2'd0;
  localparam logic [1:0] PH_DECODE  = 2'd1;
  localparam logic [1:0] PH_DISCARD = 2'd2;

  localparam logic [1:0] PR_NO   = 2'd0;
  localparam logic [1:0] PR_YES  = 2'd1;
  localparam logic [1:0] PR_WAIT = 2'd2;

  typedef struct packed {
    logic       done;
    logic [2:0] enc;
    logic [2:0] used;
  } dcs_t;

  // Compare lookahead byte i with v; a byte not yet seen is unknown, or a
  // mismatch once the stream has ended.
  function automatic logic [1:0] probe(input logic [31:0] la, input logic [2:0] cnt,
                                       input logic [1:0] i, input logic [7:0] v,
                                       input logic fin);
    if ({1'b0, i} < cnt) begin
      return (la[8*i +: 8] == v) ? PR_YES : PR_NO;
    end
    return fin ? PR_NO : PR_WAIT;
  endfunction

  function automatic dcs_t decide(input logic [31:0] la, input logic [2:0] cnt,
                                  input logic fin);
    dcs_t       r;
    logic [1:0] t;
    r.done = 1'b1;
    r.enc  = ENC_NONE;
    r.used = 3'd0;
    if (probe(la, cnt, 2'd0, 8'hFF, fin) == PR_YES) begin
      t = probe(la, cnt, 2'd1, 8'hFE, fin);
      if (t == PR_WAIT) begin
        r.done = 1'b0;
      end else if (t == PR_YES) begin
        t = probe(la, cnt, 2'd2, 8'h00, fin);
        if (t == PR_WAIT) begin
          r.done = 1'b0;
        end else if (t == PR_YES) begin
          t = probe(la, cnt, 2'd3, 8'h00, fin);
          if (t == PR_WAIT) begin
            r.done = 1'b0;
          end else if (t == PR_YES) begin
            r.enc  = ENC_UTF32LE;
            r.used = 3'd4;
          end else begin
            r.enc  = ENC_UTF16LE;
            r.used = 3'd2;
          end
        end else begin
          r.enc  = ENC_UTF16LE;
          r.used = 3'd2;
        end
      end
    end else if (probe(la, cnt, 2'd0, 8'hFE, fin) == PR_YES) begin
      t = probe(la, cnt, 2'd1, 8'hFF, fin);
      if (t == PR_WAIT) begin
        r.done = 1'b0;
      end else if (t == PR_YES) begin
        r.enc  = ENC_UTF16BE;
        r.used = 3'd2;
      end
    end else if (probe(la, cnt, 2'd0, 8'h00, fin) == PR_YES) begin
      t = probe(la, cnt, 2'd1, 8'h00, fin);
      if (t == PR_WAIT) begin
        r.done = 1'b0;
      end else if (t == PR_YES) begin
        t = probe(la, cnt, 2'd2, 8'hFE, fin);
        if (t == PR_WAIT) begin
          r.done = 1'b0;
        end else if (t == PR_YES) begin
          t = probe(la, cnt, 2'd3, 8'hFF, fin);
          if (t == PR_WAIT) begin
            r.done = 1'b0;
          end else if (t == PR_YES) begin
            r.enc  = ENC_UTF32BE;
            r.used = 3'd4;
          end
        end
      end
    end else if (probe(la, cnt, 2'd0, 8'hEF, fin) == PR_YES) begin
      t = probe(la, cnt, 2'd1, 8'hBB, fin);
      if (t == PR_WAIT) begin
        r.done = 1'b0;
      end else if (t == PR_YES) begin
        t = probe(la, cnt, 2'd2, 8'hBF, fin);
        if (t == PR_WAIT) begin
          r.done = 1'b0;
        end else if (t == PR_YES) begin
          r.enc  = ENC_UTF8;
          r.used = 3'd3;
        end
      end
    end
    return r;
  endfunction

  logic [31:0] la_q, la_d, la_new, rep_sh;
  logic [2:0]  cnt_q, cnt_d, cnt_new;
  logic [1:0]  phase_q, phase_d;
  logic [1:0]  slot;
  logic        accept;
  dcs_t        dcs;

  assign in_ready_o = !stat_i.full;
  assign accept     = in_valid_i && !stat_i.full;

  always_comb begin
    slot    = cnt_q[1:0];
    la_new  = la_q | ({24'd0, byte_in_i} << {slot, 3'b000});
    cnt_new = {1'b0, slot} + 3'd1;
    dcs     = decide(la_new, cnt_new, end_of_text_i);
    rep_sh  = la_new >> {dcs.used, 3'b000};

    push_o          = 1'b0;
    push_op_o.op    = OP_BYTE;
    push_op_o.fin   = end_of_text_i;
    push_op_o.enc   = dcs.enc;
    push_op_o.rep_n = 2'd0;
    push_op_o.b0    = byte_in_i;
    push_op_o.b1    = 8'd0;

    la_d    = la_q;
    cnt_d   = cnt_q;
    phase_d = phase_q;

    if (accept) begin
      case (phase_q)
        PH_DETECT: begin
          if (dcs.done) begin
            push_o       = 1'b1;
            push_op_o.op = OP_DETECT;
            push_op_o.b0 = rep_sh[7:0];
            push_op_o.b1 = rep_sh[15:8];
            if (dcs.enc != ENC_NONE && cnt_new > dcs.used) begin
              push_op_o.rep_n = 2'(cnt_new - dcs.used);
            end
            la_d  = '0;
            cnt_d = '0;
            if (end_of_text_i) begin
              phase_d = PH_DETECT;
            end else if (dcs.enc == ENC_NONE) begin
              phase_d = PH_DISCARD;
            end else begin
              phase_d = PH_DECODE;
            end
          end else begin
            la_d  = la_new;
            cnt_d = cnt_new;
          end
        end
        PH_DECODE: begin
          push_o = 1'b1;
          if (end_of_text_i) begin
            phase_d = PH_DETECT;
          end
        end
        PH_DISCARD: begin
          if (end_of_text_i) begin
            push_o  = 1'b1;
            phase_d = PH_DETECT;
          end
        end
        default: begin
          phase_d = PH_DETECT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      la_q    <= '0;
      cnt_q   <= '0;
      phase_q <= PH_DETECT;
    end else begin
      la_q    <= la_d;
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/bsud_queue.sv =====
// Small operation queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module bsud_queue import bsud_pkg::*; #(
  parameter int Depth = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire op_t  push_op_i,
  input  wire logic pop_i,
  output op_t       head_o,
  output q_stat_t   stat_o
);

  localparam int AW = $clog2(Depth);
  localparam int CW = $clog2(Depth + 1);

  op_t           mem_q [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign head_o       = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == CW'(Depth));
  assign stat_o.avail = (cnt_q != '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CW'(push_i) - CW'(pop_i);
    end
  end

endmodule

`default_nettype wire

// ===== design/bsud_back.sv =====
// Back end: decodes queued operations and sends results through an output register.
`timescale 1ns / 1ps
`default_nettype none

module bsud_back import bsud_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire op_t     head_i,
  input  wire q_stat_t stat_i,
  output logic         pop_o,
  input  wire logic    out_ready_i,
  output logic         out_valid_o,
  output res_t         res_o,
  output logic         last_o
);

  typedef struct packed {
    logic [31:0] acc;
    logic [2:0]  pend;
    logic        emit;
    logic [31:0] cp;
  } dec_t;

  // One byte through the decoder for the selected encoding.
  function automatic dec_t dec_step(input logic [2:0] enc, input logic [31:0] acc,
                                    input logic [2:0] pend, input logic [7:0] b);
    dec_t r;
    r.acc  = acc;
    r.pend = pend;
    r.emit = 1'b0;
    r.cp   = 32'd0;
    case (enc)
      ENC_UTF8: begin
        if (pend == 3'd0) begin
          if (b inside {[8'hFC:8'hFF]}) begin
            r.acc  = {31'd0, b[0]};
            r.pend = 3'd5;
          end else if (b inside {[8'hF8:8'hFB]}) begin
            r.acc  = {30'd0, b[1:0]};
            r.pend = 3'd4;
          end else if (b inside {[8'hF0:8'hF7]}) begin
            r.acc  = {29'd0, b[2:0]};
            r.pend = 3'd3;
          end else if (b inside {[8'hE0:8'hEF]}) begin
            r.acc  = {28'd0, b[3:0]};
            r.pend = 3'd2;
          end else if (b inside {[8'hC0:8'hDF]}) begin
            r.acc  = {27'd0, b[4:0]};
            r.pend = 3'd1;
          end else begin
            r.emit = 1'b1;
            r.cp   = {24'd0, b};
          end
        end else begin
          r.acc  = {acc[25:0], b[5:0]};
          r.pend = pend - 3'd1;
          if (r.pend == 3'd0) begin
            r.emit = 1'b1;
            r.cp   = r.acc;
            r.acc  = 32'd0;
          end
        end
      end
      ENC_UTF16BE: begin
        r.acc  = {16'd0, acc[7:0], b};
        r.pend = pend + 3'd1;
        if (r.pend == 3'd2) begin
          r.emit = 1'b1;
          r.cp   = r.acc;
          r.acc  = 32'd0;
          r.pend = 3'd0;
        end
      end
      ENC_UTF16LE: begin
        r.acc  = acc | ({24'd0, b} << {pend[0], 3'b000});
        r.pend = pend + 3'd1;
        if (r.pend == 3'd2) begin
          r.emit = 1'b1;
          r.cp   = r.acc;
          r.acc  = 32'd0;
          r.pend = 3'd0;
        end
      end
      ENC_UTF32BE: begin
        r.acc  = {acc[23:0], b};
        r.pend = pend + 3'd1;
        if (r.pend == 3'd4) begin
          r.emit = 1'b1;
          r.cp   = r.acc;
          r.acc  = 32'd0;
          r.pend = 3'd0;
        end
      end
      ENC_UTF32LE: begin
        r.acc  = acc | ({24'd0, b} << {pend[1:0], 3'b000});
        r.pend = pend + 3'd1;
        if (r.pend == 3'd4) begin
          r.emit = 1'b1;
          r.cp   = r.acc;
          r.acc  = 32'd0;
          r.pend = 3'd0;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  logic [2:0]  enc_q, enc_d, st_enc;
  logic [31:0] acc_q, acc_d, st_acc;
  logic [2:0]  pend_q, pend_d, st_pend;
  logic [1:0]  idx_q, idx_d, n;
  logic        out_valid_q, out_valid_d;
  res_t        res_q;
  logic        last_q;
  dec_t        d_rep0, d_rep1, d_byte;
  res_t        res [3];
  res_t        res_sel;
  logic        can_load, load, res_last, done;

  assign d_rep0 = dec_step(head_i.enc, 32'd0, 3'd0, head_i.b0);
  assign d_rep1 = dec_step(head_i.enc, d_rep0.acc, d_rep0.pend, head_i.b1);
  assign d_byte = dec_step(enc_q, acc_q, pend_q, head_i.b0);

  // Result list of the operation at the head of the queue.
  always_comb begin
    res[0]  = '0;
    res[1]  = '0;
    res[2]  = '0;
    n       = 2'd0;
    st_enc  = enc_q;
    st_acc  = acc_q;
    st_pend = pend_q;
    if (head_i.op == OP_DETECT) begin
      res[0]  = '{kind: KIND_ENC, cp: 32'd0, enc: head_i.enc};
      n       = 2'd1;
      st_enc  = head_i.enc;
      st_acc  = 32'd0;
      st_pend = 3'd0;
      if (head_i.rep_n != 2'd0) begin
        st_acc  = d_rep0.acc;
        st_pend = d_rep0.pend;
        if (d_rep0.emit) begin
          res[n] = '{kind: KIND_CP, cp: d_rep0.cp, enc: head_i.enc};
          n      = n + 2'd1;
        end
      end
      if (head_i.rep_n == 2'd2) begin
        st_acc  = d_rep1.acc;
        st_pend = d_rep1.pend;
        if (d_rep1.emit) begin
          res[n] = '{kind: KIND_CP, cp: d_rep1.cp, enc: head_i.enc};
          n      = n + 2'd1;
        end
      end
    end else begin
      st_acc  = d_byte.acc;
      st_pend = d_byte.pend;
      if (d_byte.emit) begin
        res[n] = '{kind: KIND_CP, cp: d_byte.cp, enc: enc_q};
        n      = n + 2'd1;
      end
    end
    if (head_i.fin) begin
      if (st_enc == ENC_UTF8 && st_pend != 3'd0) begin
        res[n] = '{kind: KIND_TRUNC, cp: 32'd0, enc: st_enc};
        n      = n + 2'd1;
      end
      res[n] = '{kind: KIND_END, cp: 32'd0, enc: st_enc};
      n      = n + 2'd1;
    end
  end

  // Unstalled, results go one per cycle; ops retire with their last result, if any.
  always_comb begin
    can_load    = !out_valid_q || out_ready_i;
    load        = stat_i.avail && can_load;
    res_sel     = res[idx_q];
    res_last    = (idx_q == n - 2'd1);
    done        = load && (n == 2'd0 || res_last);
    pop_o       = done;
    out_valid_d = can_load ? (stat_i.avail && n != 2'd0) : out_valid_q;

    idx_d = idx_q;
    if (load && n != 2'd0) begin
      idx_d = res_last ? 2'd0 : idx_q + 2'd1;
    end

    enc_d  = enc_q;
    acc_d  = acc_q;
    pend_d = pend_q;
    if (done) begin
      if (head_i.fin) begin
        enc_d  = ENC_NONE;
        acc_d  = 32'd0;
        pend_d = 3'd0;
      end else begin
        enc_d  = st_enc;
        acc_d  = st_acc;
        pend_d = st_pend;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_q       <= ENC_NONE;
      acc_q       <= '0;
      pend_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      enc_q       <= enc_d;
      acc_q       <= acc_d;
      pend_q      <= pend_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && n != 2'd0) begin
      res_q  <= res_sel;
      last_q <= res_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

// ===== design/bom_sniffing_unicode_decoder_unit.sv =====
// Top level of the byte-order-mark sniffing text decoder.
//
// This block takes a text stream one byte per transaction, with end_of_text_i
// flagging the final byte, and returns result transactions: an encoding
// report once the byte order mark is recognized (UTF-32 LE/BE, UTF-16 LE/BE,
// UTF-8 or none), then decoded code points, a truncated-sequence error for a
// UTF-8 sequence cut off by the end, and an end-of-text result after the
// final byte. last_o marks the final result caused by one input byte. UTF-8
// is decoded in the legacy form of up to six bytes without checking
// continuation bytes; UTF-16 surrogates pass through uncombined; a partial
// UTF-16 or UTF-32 unit at the end is dropped; a stream without a mark only
// reports encoding none and its end. The front end holds up to four bytes of
// lookahead while the mark is undecided and writes at most one operation
// per byte into a queue of QDepth entries (2 to 16); the back end decodes
// operations and drives a registered output. Unstalled, input takes one byte
// per clock. The output carries one result per clock while out_ready_i is
// high, so a byte that causes k results holds the back end until all k have
// left and a byte in the middle of a code point still passes through the
// back end; the queue absorbs such bursts and the input stalls only when it
// is full. Bytes still inside an undecided mark and bytes of a stream
// without a mark (except its final byte) never enter the queue. When the
// queue is empty and the output is free, the first result of a byte passes
// through the queue and then the output register before it is presented.
`timescale 1ns / 1ps
`default_nettype none

module bom_sniffing_unicode_decoder_unit import bsud_pkg::*; #(
  parameter int QDepth = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  byte_in_i,
  input  wire logic        end_of_text_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       kind_o,
  output logic [31:0]      code_point_o,
  output logic [2:0]       encoding_o,
  output logic             last_o
);

  q_stat_t q_stat;
  op_t     push_op;
  op_t     head_op;
  logic    push;
  logic    pop;
  res_t    res;

  // Mark detection and operation generation.
  bsud_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .byte_in_i     (byte_in_i),
    .end_of_text_i (end_of_text_i),
    .stat_i        (q_stat),
    .push_o        (push),
    .push_op_o     (push_op)
  );

  // Decouples the two halves so either side can stall on its own.
  bsud_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .pop_i     (pop),
    .head_o    (head_op),
    .stat_o    (q_stat)
  );

  // Decoding and result sequencing into the output register.
  bsud_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_op),
    .stat_i      (q_stat),
    .pop_o       (pop),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .res_o       (res),
    .last_o      (last_o)
  );

  assign kind_o       = res.kind;
  assign code_point_o = res.cp;
  assign encoding_o   = res.enc;

endmodule

`default_nettype wire

// ===== design/bsud_checker.sv =====
// Port-level checker for the decoder and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bsud_checker import bsud_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [7:0]  byte_in_i,
  input wire logic        end_of_text_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [1:0]  kind_o,
  input wire logic [31:0] code_point_o,
  input wire logic [2:0]  encoding_o,
  input wire logic        last_o
);

  // A stalled result transaction keeps its payload.
  `BSUD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(kind_o) && $stable(code_point_o) && $stable(encoding_o) && $stable(last_o))

  // Only code point results carry a nonzero value.
  `BSUD_ASSERT_IMP(a_cp_zero, clk_i, rst_ni, out_valid_o && kind_o != KIND_CP, code_point_o == 32'd0)

  // The end-of-text result always closes the results of its byte.
  `BSUD_ASSERT_IMP(a_end_last, clk_i, rst_ni, out_valid_o && kind_o == KIND_END, last_o)

  // A truncation error only comes from UTF-8 and is followed by the end result.
  `BSUD_ASSERT_IMP(a_trunc, clk_i, rst_ni, out_valid_o && kind_o == KIND_TRUNC, encoding_o == ENC_UTF8 && !last_o)

endmodule

bind bom_sniffing_unicode_decoder_unit bsud_checker u_bsud_checker (.*);

`default_nettype wire
